### rtl/assert_macros.svh
// Assertion helpers, sampled on clk_i; LFC_ASSERT is disabled while rst_ni is low, LFC_ASSERT_ALWAYS is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define LFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/lfc_pkg.sv
package lfc_pkg;

  localparam int unsigned SEEN_DEPTH_DEF    = 256;
  localparam int unsigned MAX_FRAMES_DEF    = 64;
  localparam int unsigned KEY_MAX_BYTES_DEF = 16;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned KEY_W    = 2 * WORD_W + LEN_W;
  localparam int unsigned FRAMES_W = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 8;

  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 7'd16;

  localparam logic [STATUS_W-1:0] ST_NEW        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_KNOWN      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RESIDENT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FRONT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_NOTFOUND, S_FOUND, S_EV_CHK, S_EV_RD,
    S_EV_WR, S_MV_RD, S_MV_WR, S_PF1, S_PF2, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_ACCEPT, CMD_CMP, CMD_NEW, CMD_FOUND, CMD_EV_CHK,
    CMD_UL_EV, CMD_UL_MV, CMD_PF1, CMD_PF2, CMD_DONE
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic in_ready;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic idx_lt_used;
    logic match;
    logic full;
    logic need_evict;
    logic resident;
    logic at_front;
    logic out_free;
  } stat_t;

endpackage

### rtl/lfc_intf.sv
interface lfc_key_if;
  logic                             valid;
  logic                             ready;
  logic [lfc_pkg::WORD_W-1:0]       key_word_low;
  logic [lfc_pkg::WORD_W-1:0]       key_word_high;
  logic [lfc_pkg::LEN_W-1:0]        key_bytes;
  modport source (output valid, key_word_low, key_word_high, key_bytes, input ready);
  modport sink (input valid, key_word_low, key_word_high, key_bytes, output ready);
endinterface

interface lfc_res_if;
  logic                             valid;
  logic                             ready;
  logic [lfc_pkg::STATUS_W-1:0]     status;
  logic [lfc_pkg::SLOT_W-1:0]       entry_slot;
  modport source (output valid, status, entry_slot, input ready);
  modport sink (input valid, status, entry_slot, output ready);
endinterface

interface lfc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lfc_pkg::FRAMES_W-1:0]     data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/lru_flow_cache_reference_core.sv
// LRU flow-key cache. Each key item is looked up in a table of all keys seen so far
// by a linear scan, a read and a compare state per stored key, then the LRU list is
// updated in link memories, with an unlink step per eviction. The next key is taken
// only once the result is loaded into the output register. One result item is
// produced for every key item, and a new key is accepted while the previous result
// waits in the output register.
module lru_flow_cache_reference_core #(
  parameter int unsigned SEEN_DEPTH    = lfc_pkg::SEEN_DEPTH_DEF,
  parameter int unsigned MAX_FRAMES    = lfc_pkg::MAX_FRAMES_DEF,
  parameter int unsigned KEY_MAX_BYTES = lfc_pkg::KEY_MAX_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfc_key_if.sink     key_i,
  lfc_cfg_if.sink     cfg_i,
  lfc_res_if.source   res_o
);
  lfc_pkg::ctrl_t ctrl;
  lfc_pkg::stat_t stat;

  assign key_i.ready = ctrl.in_ready;
  assign cfg_i.ready = 1'b1;

  lfc_ctrl u_ctrl (.clk_i, .rst_ni, .stat_i(stat), .ctrl_o(ctrl));

  lfc_dp #(
    .SEEN_DEPTH(SEEN_DEPTH), .MAX_FRAMES(MAX_FRAMES), .KEY_MAX_BYTES(KEY_MAX_BYTES)
  ) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .in_valid_i(key_i.valid), .key_word_low_i(key_i.key_word_low),
    .key_word_high_i(key_i.key_word_high), .key_bytes_i(key_i.key_bytes),
    .cfg_valid_i(cfg_i.valid), .cfg_data_i(cfg_i.data),
    .out_valid_o(res_o.valid), .out_ready_i(res_o.ready),
    .status_o(res_o.status), .entry_slot_o(res_o.entry_slot)
  );
endmodule

### rtl/lfc_ram.sv
module lfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### rtl/lfc_ctrl.sv
module lfc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lfc_pkg::stat_t stat_i,
  output lfc_pkg::ctrl_t ctrl_o
);
  lfc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lfc_pkg::S_IDLE: begin
        if (stat_i.in_valid) state_d = lfc_pkg::S_SCAN_RD;
      end
      lfc_pkg::S_SCAN_RD: begin
        state_d = stat_i.idx_lt_used ? lfc_pkg::S_SCAN_CMP : lfc_pkg::S_NOTFOUND;
      end
      lfc_pkg::S_SCAN_CMP: begin
        state_d = stat_i.match ? lfc_pkg::S_FOUND : lfc_pkg::S_SCAN_RD;
      end
      lfc_pkg::S_NOTFOUND: begin
        state_d = stat_i.full ? lfc_pkg::S_DONE : lfc_pkg::S_EV_CHK;
      end
      lfc_pkg::S_FOUND: begin
        if (!stat_i.resident) state_d = lfc_pkg::S_EV_CHK;
        else if (!stat_i.at_front) state_d = lfc_pkg::S_MV_RD;
        else state_d = lfc_pkg::S_DONE;
      end
      lfc_pkg::S_EV_CHK: begin
        state_d = stat_i.need_evict ? lfc_pkg::S_EV_RD : lfc_pkg::S_PF1;
      end
      lfc_pkg::S_EV_RD: state_d = lfc_pkg::S_EV_WR;
      lfc_pkg::S_EV_WR: state_d = lfc_pkg::S_EV_CHK;
      lfc_pkg::S_MV_RD: state_d = lfc_pkg::S_MV_WR;
      lfc_pkg::S_MV_WR: state_d = lfc_pkg::S_PF1;
      lfc_pkg::S_PF1:   state_d = lfc_pkg::S_PF2;
      lfc_pkg::S_PF2:   state_d = lfc_pkg::S_DONE;
      lfc_pkg::S_DONE: begin
        if (stat_i.out_free) state_d = lfc_pkg::S_IDLE;
      end
      default: state_d = lfc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.cmd      = lfc_pkg::CMD_NONE;
    ctrl_o.in_ready = 1'b0;
    case (state_q)
      lfc_pkg::S_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (stat_i.in_valid) ctrl_o.cmd = lfc_pkg::CMD_ACCEPT;
      end
      lfc_pkg::S_SCAN_CMP: ctrl_o.cmd = lfc_pkg::CMD_CMP;
      lfc_pkg::S_NOTFOUND: ctrl_o.cmd = lfc_pkg::CMD_NEW;
      lfc_pkg::S_FOUND:    ctrl_o.cmd = lfc_pkg::CMD_FOUND;
      lfc_pkg::S_EV_CHK:   ctrl_o.cmd = lfc_pkg::CMD_EV_CHK;
      lfc_pkg::S_EV_WR:    ctrl_o.cmd = lfc_pkg::CMD_UL_EV;
      lfc_pkg::S_MV_WR:    ctrl_o.cmd = lfc_pkg::CMD_UL_MV;
      lfc_pkg::S_PF1:      ctrl_o.cmd = lfc_pkg::CMD_PF1;
      lfc_pkg::S_PF2:      ctrl_o.cmd = lfc_pkg::CMD_PF2;
      lfc_pkg::S_DONE:     ctrl_o.cmd = lfc_pkg::CMD_DONE;
      default:             ctrl_o.cmd = lfc_pkg::CMD_NONE;
    endcase
  end

`include "assert_macros.svh"

  `LFC_ASSERT(a_ready_idle_only, ctrl_o.in_ready |-> state_q == lfc_pkg::S_IDLE, "ready outside idle")
  `LFC_ASSERT(a_pf_order, state_q == lfc_pkg::S_PF1 |=> state_q == lfc_pkg::S_PF2, "push out of order")
  `LFC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> state_q == lfc_pkg::S_IDLE, "not idle in reset")
endmodule

### rtl/lfc_dp.sv
module lfc_dp #(
  parameter int unsigned SEEN_DEPTH    = lfc_pkg::SEEN_DEPTH_DEF,
  parameter int unsigned MAX_FRAMES    = lfc_pkg::MAX_FRAMES_DEF,
  parameter int unsigned KEY_MAX_BYTES = lfc_pkg::KEY_MAX_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lfc_pkg::ctrl_t                 ctrl_i,
  output lfc_pkg::stat_t                 stat_o,
  input  logic                           in_valid_i,
  input  logic [lfc_pkg::WORD_W-1:0]     key_word_low_i,
  input  logic [lfc_pkg::WORD_W-1:0]     key_word_high_i,
  input  logic [lfc_pkg::LEN_W-1:0]      key_bytes_i,
  input  logic                           cfg_valid_i,
  input  logic [lfc_pkg::FRAMES_W-1:0]   cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lfc_pkg::STATUS_W-1:0]   status_o,
  output logic [lfc_pkg::SLOT_W-1:0]     entry_slot_o
);
  localparam int unsigned SW = $clog2(SEEN_DEPTH);
  localparam int unsigned UW = $clog2(SEEN_DEPTH + 1);
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned KMAX = KEY_MAX_BYTES;

  logic [lfc_pkg::FRAMES_W-1:0] frames_q;
  logic [lfc_pkg::WORD_W-1:0]   lo_q, hi_q;
  logic [lfc_pkg::LEN_W-1:0]    len_q;
  logic [UW-1:0]                idx_q, used_q;
  logic [SW-1:0]                s_q, ulx_q, front_q, rear_q;
  logic [CW-1:0]                count_q, limit;
  logic [SEEN_DEPTH-1:0]        flag_q;
  logic [lfc_pkg::STATUS_W-1:0] res_status_q, status_q;
  logic [lfc_pkg::SLOT_W-1:0]   slot_q;
  logic                         out_valid_q;

  logic [lfc_pkg::LEN_W-1:0]    len_sat;
  logic [lfc_pkg::WORD_W-1:0]   lo_m, hi_m;
  logic [31:0]                  lim_wide;
  logic [lfc_pkg::KEY_W-1:0]    key_rd;
  logic                         key_we, lf_we, lr_we;
  logic [SW-1:0]                lf_wa, lr_wa, p_rd, n_rd;
  logic [SW-1:0]                lf_wd, lr_wd;
  logic                         out_free;

  always_comb begin
    len_sat = (32'(key_bytes_i) > KMAX) ? lfc_pkg::LEN_W'(KMAX) : key_bytes_i;
    for (int b = 0; b < 8; b++) begin
      lo_m[8*b +: 8] = (b < 32'(len_sat)) ? key_word_low_i[8*b +: 8] : 8'd0;
      hi_m[8*b +: 8] = (b + 8 < 32'(len_sat)) ? key_word_high_i[8*b +: 8] : 8'd0;
    end
    if (frames_q == '0) lim_wide = 32'd1;
    else if (32'(frames_q) > MAX_FRAMES) lim_wide = MAX_FRAMES;
    else lim_wide = 32'(frames_q);
    limit = lim_wide[CW-1:0];
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.in_valid    = in_valid_i;
    stat_o.idx_lt_used = idx_q < used_q;
    stat_o.match       = key_rd == {len_q, hi_q, lo_q};
    stat_o.full        = 32'(used_q) >= SEEN_DEPTH;
    stat_o.need_evict  = (count_q >= limit) && (count_q != '0);
    stat_o.resident    = flag_q[s_q];
    stat_o.at_front    = s_q == front_q;
    stat_o.out_free    = out_free;
  end

  always_comb begin
    key_we = (ctrl_i.cmd == lfc_pkg::CMD_NEW) && !stat_o.full;
    lf_we  = 1'b0;
    lf_wa  = s_q;
    lf_wd  = s_q;
    lr_we  = 1'b0;
    lr_wa  = s_q;
    lr_wd  = front_q;
    case (ctrl_i.cmd)
      lfc_pkg::CMD_UL_EV, lfc_pkg::CMD_UL_MV: begin
        lf_we = ulx_q != rear_q;
        lf_wa = n_rd;
        lf_wd = p_rd;
        lr_we = ulx_q != front_q;
        lr_wa = p_rd;
        lr_wd = n_rd;
      end
      lfc_pkg::CMD_PF1: begin
        lf_we = count_q != '0;
        lf_wa = front_q;
        lr_we = count_q != '0;
      end
      lfc_pkg::CMD_PF2: lf_we = 1'b1;
      default: ;
    endcase
  end

  lfc_ram #(.WIDTH(lfc_pkg::KEY_W), .DEPTH(SEEN_DEPTH)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(used_q[SW-1:0]), .wdata_i({len_q, hi_q, lo_q}),
    .raddr_i(idx_q[SW-1:0]), .rdata_o(key_rd)
  );

  lfc_ram #(.WIDTH(SW), .DEPTH(SEEN_DEPTH)) u_front_ram (
    .clk_i, .we_i(lf_we), .waddr_i(lf_wa), .wdata_i(lf_wd),
    .raddr_i(ulx_q), .rdata_o(p_rd)
  );

  lfc_ram #(.WIDTH(SW), .DEPTH(SEEN_DEPTH)) u_rear_ram (
    .clk_i, .we_i(lr_we), .waddr_i(lr_wa), .wdata_i(lr_wd),
    .raddr_i(ulx_q), .rdata_o(n_rd)
  );

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      lfc_pkg::CMD_ACCEPT: begin
        lo_q  <= lo_m;
        hi_q  <= hi_m;
        len_q <= len_sat;
      end
      lfc_pkg::CMD_CMP: if (stat_o.match) s_q <= idx_q[SW-1:0];
      lfc_pkg::CMD_NEW: begin
        if (stat_o.full) begin
          res_status_q <= lfc_pkg::ST_TABLE_FULL;
          s_q          <= '0;
        end else begin
          res_status_q <= lfc_pkg::ST_NEW;
          s_q          <= used_q[SW-1:0];
        end
      end
      lfc_pkg::CMD_FOUND: begin
        ulx_q <= s_q;
        if (!stat_o.resident) res_status_q <= lfc_pkg::ST_KNOWN;
        else if (!stat_o.at_front) res_status_q <= lfc_pkg::ST_RESIDENT;
        else res_status_q <= lfc_pkg::ST_FRONT;
      end
      lfc_pkg::CMD_EV_CHK: ulx_q <= rear_q;
      default: ;
    endcase
    if (ctrl_i.cmd == lfc_pkg::CMD_DONE && out_free) begin
      status_q <= res_status_q;
      slot_q   <= lfc_pkg::SLOT_W'(s_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= lfc_pkg::FRAMES_RESET;
      idx_q       <= '0;
      used_q      <= '0;
      front_q     <= '0;
      rear_q      <= '0;
      count_q     <= '0;
      flag_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) frames_q <= cfg_data_i;
      case (ctrl_i.cmd)
        lfc_pkg::CMD_ACCEPT: idx_q <= '0;
        lfc_pkg::CMD_CMP: if (!stat_o.match) idx_q <= idx_q + 1'b1;
        lfc_pkg::CMD_NEW: if (!stat_o.full) used_q <= used_q + 1'b1;
        lfc_pkg::CMD_UL_EV, lfc_pkg::CMD_UL_MV: begin
          if (ulx_q == front_q) front_q <= n_rd;
          if (ulx_q == rear_q) rear_q <= p_rd;
          count_q <= count_q - 1'b1;
          if (ctrl_i.cmd == lfc_pkg::CMD_UL_EV) flag_q[ulx_q] <= 1'b0;
        end
        lfc_pkg::CMD_PF2: begin
          if (count_q == '0) rear_q <= s_q;
          front_q      <= s_q;
          flag_q[s_q]  <= 1'b1;
          count_q      <= count_q + 1'b1;
        end
        default: ;
      endcase
      if (ctrl_i.cmd == lfc_pkg::CMD_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign entry_slot_o = slot_q;

`include "assert_macros.svh"

  `LFC_ASSERT(a_count_bound, 32'(count_q) <= MAX_FRAMES, "resident count above limit")
  `LFC_ASSERT(a_push_nonempty, ctrl_i.cmd == lfc_pkg::CMD_PF2 |=> count_q != '0, "empty after push")
  `LFC_ASSERT(a_full_slot, out_valid_q && status_q == lfc_pkg::ST_TABLE_FULL |-> slot_q == '0, "full slot")
endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [lfc_pkg::WORD_W-1:0] lo;
    logic [lfc_pkg::WORD_W-1:0] hi;
    logic [lfc_pkg::LEN_W-1:0]  len;
  } key_item_t;

  typedef struct packed {
    logic [lfc_pkg::STATUS_W-1:0] status;
    logic [lfc_pkg::SLOT_W-1:0]   slot;
  } lookup_t;

  localparam int unsigned DEPTH = lfc_pkg::SEEN_DEPTH_DEF;
  localparam int unsigned IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lfc_key_if key_if ();
  lfc_res_if res_if ();
  lfc_cfg_if cfg_if ();

  lru_flow_cache_reference_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .key_i(key_if.sink), .cfg_i(cfg_if.sink),
    .res_o(res_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [lfc_pkg::WORD_W-1:0] tbl_lo [DEPTH];
  logic [lfc_pkg::WORD_W-1:0] tbl_hi [DEPTH];
  logic [lfc_pkg::LEN_W-1:0]  tbl_len [DEPTH];
  int unsigned tbl_used;
  int unsigned toward_front [DEPTH];
  int unsigned toward_rear [DEPTH];
  bit          is_resident [DEPTH];
  int unsigned lru_front, lru_rear, lru_count;
  int unsigned frame_limit;

  key_item_t pending_keys [$];
  lookup_t   expected_lookups [$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit send_hold = 1'b0;
  int unsigned burst_left = 0, gap_left = 0;
  int unsigned stall_phase = 0;

  function automatic logic [lfc_pkg::WORD_W-1:0] byte_mask(int unsigned n);
    if (n >= 8) return '1;
    if (n == 0) return '0;
    return (64'd1 << (n * 8)) - 64'd1;
  endfunction

  function automatic void lru_unlink(int unsigned s);
    int unsigned p, n;
    p = toward_front[s];
    n = toward_rear[s];
    if (s == lru_front) lru_front = n;
    else toward_rear[p % DEPTH] = n;
    if (s == lru_rear) lru_rear = p;
    else toward_front[n % DEPTH] = p;
  endfunction

  function automatic void lru_push_front(int unsigned s);
    if (lru_count == 0) begin
      lru_front = s;
      lru_rear = s;
    end else begin
      toward_front[lru_front] = s;
      toward_rear[s] = lru_front;
      lru_front = s;
    end
    toward_front[s] = s;
    is_resident[s] = 1'b1;
    lru_count++;
  endfunction

  function automatic void lru_insert(int unsigned s);
    int unsigned lim, r;
    lim = frame_limit;
    if (lim == 0) lim = 1;
    if (lim > lfc_pkg::MAX_FRAMES_DEF) lim = lfc_pkg::MAX_FRAMES_DEF;
    while (lru_count >= lim && lru_count > 0) begin
      r = lru_rear % DEPTH;
      lru_unlink(r);
      is_resident[r] = 1'b0;
      lru_count--;
    end
    lru_push_front(s);
  endfunction

  function automatic lookup_t predict_lookup(key_item_t k);
    lookup_t r;
    int unsigned len, s;
    logic [lfc_pkg::WORD_W-1:0] lo, hi;
    bit found;
    len = 32'(k.len);
    if (len > lfc_pkg::KEY_MAX_BYTES_DEF) len = lfc_pkg::KEY_MAX_BYTES_DEF;
    lo = k.lo & byte_mask(len);
    hi = (len > 8) ? (k.hi & byte_mask(len - 8)) : '0;
    found = 1'b0;
    s = 0;
    for (int unsigned i = 0; i < tbl_used; i++) begin
      if (!found && tbl_len[i] == len && tbl_lo[i] == lo && tbl_hi[i] == hi) begin
        s = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      if (tbl_used >= DEPTH) begin
        r.status = lfc_pkg::ST_TABLE_FULL;
        r.slot = '0;
        return r;
      end
      s = tbl_used;
      tbl_lo[s] = lo;
      tbl_hi[s] = hi;
      tbl_len[s] = lfc_pkg::LEN_W'(len);
      tbl_used++;
      lru_insert(s);
      r.status = lfc_pkg::ST_NEW;
    end else if (!is_resident[s]) begin
      lru_insert(s);
      r.status = lfc_pkg::ST_KNOWN;
    end else if (s != lru_front) begin
      lru_unlink(s);
      lru_count--;
      lru_push_front(s);
      r.status = lfc_pkg::ST_RESIDENT;
    end else begin
      r.status = lfc_pkg::ST_FRONT;
    end
    r.slot = s[lfc_pkg::SLOT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // Key driver. While send_hold is set, each item waits until the previous result is back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_if.valid <= 1'b0;
      key_if.key_word_low <= '0;
      key_if.key_word_high <= '0;
      key_if.key_bytes <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (key_if.valid && key_if.ready) begin
        expected_lookups.push_back(predict_lookup({key_if.key_word_low,
            key_if.key_word_high, key_if.key_bytes}));
      end
      if (!key_if.valid || key_if.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          key_if.valid <= 1'b0;
        end else if (pending_keys.size() > 0
                     && !(send_hold && expected_lookups.size() > 0)) begin
          key_item_t k;
          k = pending_keys.pop_front();
          key_if.valid <= 1'b1;
          key_if.key_word_low <= k.lo;
          key_if.key_word_high <= k.hi;
          key_if.key_bytes <= k.len;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          key_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with its own stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_phase <= 0;
      idle_cycles <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        lookup_t want;
        if (expected_lookups.size() == 0) begin
          report_mismatch("unexpected item, status", 32'(res_if.status), 0);
        end else begin
          want = expected_lookups.pop_front();
          if (res_if.status !== want.status)
            report_mismatch("status", 32'(res_if.status), 32'(want.status));
          if (res_if.entry_slot !== want.slot)
            report_mismatch("entry_slot", 32'(res_if.entry_slot), 32'(want.slot));
        end
      end
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:8] == 2'd0) res_if.ready <= 1'b1;
      else if (stall_phase[9:8] == 2'd1) res_if.ready <= stall_phase[2:0] != 3'd5;
      else res_if.ready <= $urandom_range(0, 3) != 0;
      if ((res_if.valid && res_if.ready) || (key_if.valid && key_if.ready)
          || (cfg_if.valid && cfg_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic key_item_t rand_key(int unsigned pool);
    key_item_t k;
    int unsigned id;
    k.len = lfc_pkg::LEN_W'($urandom_range(0, 31));
    if (pool != 0) begin
      id = $urandom_range(0, pool - 1);
      k.lo = {32'h0, id} * 64'h9e37_79b9_7f4a_7c15;
      k.hi = {32'h0, id} * 64'hc2b2_ae3d_27d4_eb4f;
      k.len = lfc_pkg::LEN_W'(1 + id % 16);
    end else begin
      k.lo = {$urandom, $urandom};
      k.hi = {$urandom, $urandom};
    end
    return k;
  endfunction

  task automatic wait_drained();
    while (pending_keys.size() > 0 || key_if.valid || expected_lookups.size() > 0)
      @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_frames(logic [lfc_pkg::FRAMES_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    frame_limit = 32'(v);
    @(posedge clk_i);
  endtask

  initial begin
    key_item_t k;
    int unsigned fr [6];
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    tbl_used = 0;
    lru_front = 0;
    lru_rear = 0;
    lru_count = 0;
    frame_limit = 32'(lfc_pkg::FRAMES_RESET);
    for (int i = 0; i < DEPTH; i++) is_resident[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme lengths, masked bytes, repeats hitting every status but table full.
    write_frames(7'd2);
    pending_keys.push_back('{lo: '1, hi: '1, len: 5'd0});
    pending_keys.push_back('{lo: '1, hi: '1, len: 5'd31});
    pending_keys.push_back('{lo: '1, hi: '1, len: 5'd16});
    pending_keys.push_back('{lo: 64'hff, hi: 64'h0, len: 5'd1});
    pending_keys.push_back('{lo: 64'hab_cdff, hi: '1, len: 5'd1});
    pending_keys.push_back('{lo: '1, hi: 64'h1234, len: 5'd8});
    pending_keys.push_back('{lo: '1, hi: 64'h5678, len: 5'd8});
    pending_keys.push_back('{lo: '1, hi: 64'h00ff, len: 5'd9});
    pending_keys.push_back('{lo: 64'h0, hi: 64'h0, len: 5'd0});
    pending_keys.push_back('{lo: '1, hi: '1, len: 5'd17});
    pending_keys.push_back('{lo: 64'h0, hi: 64'h0, len: 5'd0});
    pending_keys.push_back('{lo: 64'hff, hi: 64'h0, len: 5'd1});
    pending_keys.push_back('{lo: '0, hi: '0, len: 5'd16});
    pending_keys.push_back('{lo: '0, hi: '0, len: 5'd15});
    wait_drained();
    // Lowering frames below the resident count.
    write_frames(7'd0);
    pending_keys.push_back('{lo: '1, hi: '1, len: 5'd16});
    pending_keys.push_back('{lo: 64'h0, hi: 64'h0, len: 5'd0});
    wait_drained();
    write_frames(7'd127);

    fr = '{64, 1, 5, 100, 3, 16};
    for (int p = 0; p < 6; p++) begin
      for (int n = 0; n < 60; n++) begin
        k = rand_key(($urandom_range(0, 4) == 0) ? 0 : 24 + p * 4);
        pending_keys.push_back(k);
      end
      send_hold = (p == 2);
      wait_drained();
      send_hold = 1'b0;
      write_frames(lfc_pkg::FRAMES_W'(fr[p]));
    end
    // Fill the seen table past its depth to reach the full condition.
    for (int n = 0; n < 160; n++) pending_keys.push_back(rand_key(0));
    wait_drained();
    for (int n = 0; n < 20; n++) pending_keys.push_back(rand_key(24));
    wait_drained();
    if (fail_count == 0 && expected_lookups.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
